[rtl/core/vnft_pkg.sv]
package vnft_pkg;

    localparam int COORD_W = 24;
    localparam int EDGE_W = 25;
    localparam int PROD_W = 50;
    localparam int CROSS_W = 51;
    localparam int SUM_W = 24;
    localparam int OUT_W = 16;
    localparam int TAG_W = 24;
    localparam int ACC_W = 64;
    localparam int LEN_W = 32;
    localparam int DIV_W = 48;
    localparam int IDX_W = 5;
    localparam int LIMIT_W = 41;
    localparam int UNIT_ONE = 16384;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul;
        logic tiny;
        logic load_face;
        logic load_sum;
        logic load_zero;
        logic norm;
        logic square;
        logic root_init;
        logic root;
        logic div_init;
        logic div;
        logic div_wr;
        logic acc_face;
        logic load_out;
        logic [IDX_W-1:0] idx;
        logic [1:0] comp;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tiny;
        logic norm_done;
        logic sum_zero;
    } status_t;

    // Squared-length threshold at or below which a face counts as degenerate.
    function automatic logic [LIMIT_W-1:0] tiny_limit(input int fb);
        logic [LIMIT_W-1:0] lim;
        case (fb)
            10: lim = LIMIT_W'(1);
            11: lim = LIMIT_W'(17);
            12: lim = LIMIT_W'(281);
            13: lim = LIMIT_W'(4503);
            14: lim = LIMIT_W'(72057);
            15: lim = LIMIT_W'(1152921);
            16: lim = LIMIT_W'(18446744);
            17: lim = LIMIT_W'(295147905);
            18: lim = LIMIT_W'(64'd4722366482);
            19: lim = LIMIT_W'(64'd75557863725);
            20: lim = LIMIT_W'(64'd1208925819614);
            default: lim = (fb > 20) ? LIMIT_W'(64'd1208925819614) : '0;
        endcase
        return lim;
    endfunction

    function automatic logic [CROSS_W-1:0] mag(input logic signed [CROSS_W-1:0] v);
        return v[CROSS_W-1] ? CROSS_W'(-v) : CROSS_W'(v);
    endfunction

endpackage

[rtl/core/vnft_ctrl.sv]
module vnft_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_last_triangle,
    input  logic               s_no_triangle,
    output logic               m_valid,
    input  logic               m_ready,
    input  vnft_pkg::status_t  status,
    output vnft_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_TINY, S_TDEC, S_NORM, S_SQ, S_RINIT, S_ROOT,
        S_DINIT, S_DIV, S_DWR, S_ACC, S_END, S_OUT
    } state_t;

    state_t state_reg;
    logic [vnft_pkg::IDX_W-1:0] idx_reg;
    logic [1:0] comp_reg;
    logic end_reg;
    logic face_reg;
    logic m_valid_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd = '0;
        cmd.idx = idx_reg;
        cmd.comp = comp_reg;
        case (state_reg)
            S_IDLE:  cmd.load_in = s_valid;
            S_MUL:   cmd.mul = 1'b1;
            S_TINY:  cmd.tiny = 1'b1;
            S_TDEC:  cmd.load_face = !status.tiny;
            S_NORM:  cmd.norm = !status.norm_done;
            S_SQ:    cmd.square = 1'b1;
            S_RINIT: cmd.root_init = 1'b1;
            S_ROOT:  cmd.root = 1'b1;
            S_DINIT: cmd.div_init = 1'b1;
            S_DIV:   cmd.div = 1'b1;
            S_DWR:   cmd.div_wr = 1'b1;
            S_ACC:   cmd.acc_face = 1'b1;
            S_END: begin
                cmd.load_zero = status.sum_zero;
                cmd.load_sum = !status.sum_zero;
            end
            S_OUT:   cmd.load_out = !m_valid_reg || m_ready;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            comp_reg <= '0;
            end_reg <= 1'b0;
            face_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        end_reg <= s_last_triangle || s_no_triangle;
                        idx_reg <= '0;
                        state_reg <= s_no_triangle ? S_END : S_MUL;
                    end
                end
                S_MUL: begin
                    if (idx_reg == vnft_pkg::IDX_W'(5)) begin
                        idx_reg <= '0;
                        state_reg <= S_TINY;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_TINY: begin
                    if (idx_reg == vnft_pkg::IDX_W'(2)) begin
                        state_reg <= S_TDEC;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_TDEC: begin
                    if (status.tiny) begin
                        state_reg <= end_reg ? S_END : S_IDLE;
                    end else begin
                        face_reg <= 1'b1;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (status.norm_done) begin
                        idx_reg <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (idx_reg == vnft_pkg::IDX_W'(2)) begin
                        state_reg <= S_RINIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_RINIT: begin
                    idx_reg <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    if (idx_reg == vnft_pkg::IDX_W'(31)) begin
                        comp_reg <= '0;
                        state_reg <= S_DINIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DINIT: begin
                    idx_reg <= vnft_pkg::IDX_W'(16);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (idx_reg == '0) begin
                        state_reg <= S_DWR;
                    end else begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                S_DWR: begin
                    if (comp_reg == 2'd2) begin
                        state_reg <= face_reg ? S_ACC : S_OUT;
                    end else begin
                        comp_reg <= comp_reg + 1'b1;
                        state_reg <= S_DINIT;
                    end
                end
                S_ACC: begin
                    state_reg <= end_reg ? S_END : S_IDLE;
                end
                S_END: begin
                    face_reg <= 1'b0;
                    state_reg <= status.sum_zero ? S_OUT : S_NORM;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/vnft_dp.sv]
module vnft_dp #(
    parameter int COORD_FRACTION_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  vnft_pkg::cmd_t                       cmd,
    output vnft_pkg::status_t                    status,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_ax,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_ay,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_az,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_bx,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_by,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_bz,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_cx,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_cy,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_cz,
    input  logic [vnft_pkg::TAG_W-1:0]           s_vertex_tag,
    output logic signed [vnft_pkg::OUT_W-1:0]    m_normal_x,
    output logic signed [vnft_pkg::OUT_W-1:0]    m_normal_y,
    output logic signed [vnft_pkg::OUT_W-1:0]    m_normal_z,
    output logic                                 m_degenerate,
    output logic [vnft_pkg::TAG_W-1:0]           m_vertex_out
);

    localparam int EW = vnft_pkg::EDGE_W;
    localparam int NW = vnft_pkg::CROSS_W;
    localparam int SW = vnft_pkg::SUM_W;
    localparam int OW = vnft_pkg::OUT_W;
    localparam int AW = vnft_pkg::ACC_W;
    localparam int LW = vnft_pkg::LEN_W;
    localparam int DW = vnft_pkg::DIV_W;
    localparam logic [vnft_pkg::LIMIT_W-1:0] LIMIT = vnft_pkg::tiny_limit(COORD_FRACTION_BITS);

    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [NW-1:0] n_reg [3];
    logic [NW-1:0] um_reg [3];
    logic sgn_reg [3];
    logic big_reg;
    logic [AW-1:0] acc_reg;
    logic [AW-1:0] r_reg;
    logic [AW-1:0] bit_reg;
    logic [DW-1:0] rem_reg;
    logic [16:0] q_reg;
    logic signed [OW-1:0] res_reg [3];
    logic degen_reg;
    logic [vnft_pkg::TAG_W-1:0] tag_reg;
    logic signed [SW-1:0] sum_reg [3];
    logic signed [OW-1:0] out_reg [3];
    logic out_degen_reg;
    logic [vnft_pkg::TAG_W-1:0] out_tag_reg;

    logic signed [EW-1:0] op_a, op_b;
    logic signed [vnft_pkg::PROD_W-1:0] prod;
    logic [1:0] nsel;
    logic [NW-1:0] tmag;
    logic [NW-1:0] mx;
    logic [59:0] sq_prod;
    logic [AW-1:0] cand;
    logic [LW-1:0] len;
    logic [DW-1:0] dv;
    logic [16:0] qc;

    always_comb begin
        case (cmd.idx[2:0])
            3'd0: begin op_a = e1_reg[1]; op_b = e2_reg[2]; end
            3'd1: begin op_a = e1_reg[2]; op_b = e2_reg[1]; end
            3'd2: begin op_a = e1_reg[2]; op_b = e2_reg[0]; end
            3'd3: begin op_a = e1_reg[0]; op_b = e2_reg[2]; end
            3'd4: begin op_a = e1_reg[0]; op_b = e2_reg[1]; end
            default: begin op_a = e1_reg[1]; op_b = e2_reg[0]; end
        endcase
        prod = op_a * op_b;
        nsel = cmd.idx[2:1];
        tmag = vnft_pkg::mag(n_reg[cmd.idx[1:0]]);
        mx = um_reg[0];
        if (um_reg[1] > mx) mx = um_reg[1];
        if (um_reg[2] > mx) mx = um_reg[2];
        sq_prod = um_reg[cmd.idx[1:0]][29:0] * um_reg[cmd.idx[1:0]][29:0];
        cand = r_reg + bit_reg;
        len = r_reg[LW-1:0];
        dv = DW'(len) << cmd.idx;
        qc = (q_reg > 17'(vnft_pkg::UNIT_ONE)) ? 17'(vnft_pkg::UNIT_ONE) : q_reg;
    end

    assign status.tiny = !big_reg && (acc_reg <= AW'(LIMIT));
    assign status.norm_done = (mx[NW-1:30] == '0) && mx[29];
    assign status.sum_zero = (sum_reg[0] == '0) && (sum_reg[1] == '0) && (sum_reg[2] == '0);

    assign m_normal_x = out_reg[0];
    assign m_normal_y = out_reg[1];
    assign m_normal_z = out_reg[2];
    assign m_degenerate = out_degen_reg;
    assign m_vertex_out = out_tag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            e1_reg[0] <= EW'(s_bx) - EW'(s_ax);
            e1_reg[1] <= EW'(s_by) - EW'(s_ay);
            e1_reg[2] <= EW'(s_bz) - EW'(s_az);
            e2_reg[0] <= EW'(s_cx) - EW'(s_ax);
            e2_reg[1] <= EW'(s_cy) - EW'(s_ay);
            e2_reg[2] <= EW'(s_cz) - EW'(s_az);
            tag_reg <= s_vertex_tag;
        end
        if (cmd.mul) begin
            n_reg[nsel] <= cmd.idx[0] ? n_reg[nsel] - NW'(prod) : NW'(prod);
            acc_reg <= '0;
            big_reg <= 1'b0;
        end
        if (cmd.tiny) begin
            if (tmag[NW-1:21] != '0) begin
                big_reg <= 1'b1;
            end else begin
                acc_reg <= acc_reg + AW'(tmag[20:0] * tmag[20:0]);
            end
        end
        if (cmd.load_face) begin
            for (int i = 0; i < 3; i++) begin
                um_reg[i] <= vnft_pkg::mag(n_reg[i]);
                sgn_reg[i] <= n_reg[i][NW-1];
            end
        end
        if (cmd.load_sum) begin
            for (int i = 0; i < 3; i++) begin
                um_reg[i] <= vnft_pkg::mag(NW'(sum_reg[i]));
                sgn_reg[i] <= sum_reg[i][SW-1];
            end
            degen_reg <= 1'b0;
        end
        if (cmd.load_zero) begin
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= '0;
            end
            degen_reg <= 1'b1;
        end
        if (cmd.norm) begin
            for (int i = 0; i < 3; i++) begin
                um_reg[i] <= (mx[NW-1:30] != '0) ? (um_reg[i] >> 1) : (um_reg[i] << 1);
            end
        end
        if (cmd.square) begin
            acc_reg <= ((cmd.idx == '0) ? '0 : acc_reg) + AW'(sq_prod);
        end
        if (cmd.root_init) begin
            r_reg <= '0;
            bit_reg <= AW'(1) << 62;
        end
        if (cmd.root) begin
            if (acc_reg >= cand) begin
                acc_reg <= acc_reg - cand;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init) begin
            rem_reg <= {DW'(um_reg[cmd.comp][29:0]) << 14} + DW'(len >> 1);
            q_reg <= '0;
        end
        if (cmd.div) begin
            if (rem_reg >= dv) begin
                rem_reg <= rem_reg - dv;
                q_reg[cmd.idx] <= 1'b1;
            end
        end
        if (cmd.div_wr) begin
            res_reg[cmd.comp] <= sgn_reg[cmd.comp] ? -OW'(qc) : OW'(qc);
        end
        if (cmd.load_out) begin
            for (int i = 0; i < 3; i++) begin
                out_reg[i] <= res_reg[i];
            end
            out_degen_reg <= degen_reg;
            out_tag_reg <= tag_reg;
        end
    end

    // Running sums of unit face normals, saturating at the 24-bit limits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (cmd.load_out) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (cmd.acc_face) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [SW:0] t;
                t = (SW+1)'(sum_reg[i]) + (SW+1)'(res_reg[i]);
                if (t[SW] != t[SW-1]) begin
                    sum_reg[i] <= t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
                end else begin
                    sum_reg[i] <= t[SW-1:0];
                end
            end
        end
    end

endmodule

[rtl/core/vertex_normal_from_triangles.sv]
// Vertex normal from adjacent triangles. Each input transaction carries one
// triangle next to the current vertex (three corners in signed fixed point
// with COORD_FRACTION_BITS fraction bits) or, with s_no_triangle set, no
// triangle at all. The face normal (cross product of the edge vectors from the
// first corner) is dropped when its squared length is at or below a tiny
// threshold, otherwise scaled to unit length in Q1.14 and added to a
// saturating 24-bit sum. The transaction with s_last_triangle or
// s_no_triangle set ends the vertex: one result transaction follows with
// the unit-length sum in Q1.14 and the vertex tag, and the sum is cleared.
// A zero sum yields a zero normal with m_degenerate set. One transaction is
// processed at a time. A non-degenerate triangle passes through the cross
// product on the shared 25x25 multiplier, the size test, single-bit
// normalization shifts, squaring, the bit-serial square root and three
// restoring divisions for the components. A tiny triangle stops after the
// size test. Ending a vertex adds one more unit scaling of the sum before
// the result is presented. The result sits in an output register, so new
// input transactions are taken while it waits.
module vertex_normal_from_triangles #(
    parameter int COORD_FRACTION_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_ax,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_ay,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_az,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_bx,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_by,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_bz,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_cx,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_cy,
    input  logic signed [vnft_pkg::COORD_W-1:0]  s_cz,
    input  logic                                 s_last_triangle,
    input  logic                                 s_no_triangle,
    input  logic [vnft_pkg::TAG_W-1:0]           s_vertex_tag,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vnft_pkg::OUT_W-1:0]    m_normal_x,
    output logic signed [vnft_pkg::OUT_W-1:0]    m_normal_y,
    output logic signed [vnft_pkg::OUT_W-1:0]    m_normal_z,
    output logic                                 m_degenerate,
    output logic [vnft_pkg::TAG_W-1:0]           m_vertex_out
);

    vnft_pkg::cmd_t    cmd;
    vnft_pkg::status_t status;

    // The controller sequences the shared multiplier, root and divider.
    vnft_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_last_triangle (s_last_triangle),
        .s_no_triangle   (s_no_triangle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .status          (status),
        .cmd             (cmd)
    );

    // The datapath holds the operands, the sums and the output register.
    vnft_dp #(
        .COORD_FRACTION_BITS (COORD_FRACTION_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_az         (s_az),
        .s_bx         (s_bx),
        .s_by         (s_by),
        .s_bz         (s_bz),
        .s_cx         (s_cx),
        .s_cy         (s_cy),
        .s_cz         (s_cz),
        .s_vertex_tag (s_vertex_tag),
        .m_normal_x   (m_normal_x),
        .m_normal_y   (m_normal_y),
        .m_normal_z   (m_normal_z),
        .m_degenerate (m_degenerate),
        .m_vertex_out (m_vertex_out)
    );

endmodule
